// ----- rtl/rmm_pkg.sv -----
package rmm_pkg;

	// Default state widths.
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_COUNT_WIDTH = 32;

	// Stream payload widths.
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 1;

	// Field width of the counts and means on the streams.
	localparam int FIELD_W = 32;

endpackage

// ----- rtl/running_mean_merge.sv -----
// Channel  Direction  Width       Contents (lowest bit first)
// s_*      in         64 + 1      tdata: sample_count, sample_mean; tuser: restart
// m_*      out        64 + 1      tdata: total_count, mean_value; tuser: count_saturated
//
// A merge that needs the weighted update runs setup, the divide loop, an apply step and the
// final step, which loads its result into the output register.
// The radix-2 divide loop works through one mean bit per cycle.
// Restart-only, zero-count and empty-state requests skip the divide: setup, then the final step.
// The block takes one request at a time; s_tready is high only while it is idle.
// The result sits in an output register, so a new request is taken while it waits.
// A stalled result holds the block in its final step until the output register frees.
// Reset clears the count and the mean to zero; there is no clearing pass.
module running_mean_merge
	import rmm_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample_count[31:0], sample_mean[63:32]
	input  logic [IN_USER_W-1:0]  s_tuser,   // restart[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // total_count[31:0], mean_value[63:32]
	output logic [OUT_USER_W-1:0] m_tuser    // count_saturated[0]
);

	localparam int VW = VALUE_WIDTH;
	localparam int CW = COUNT_WIDTH;
	localparam int BW = $clog2(VW);

	// Input clamp limits expressed on the 32-bit stream fields.
	localparam logic signed [FIELD_W-1:0] VMAX32 = (VW >= FIELD_W) ? 32'sh7fff_ffff :
		FIELD_W'((64'd1 << (VW - 1)) - 64'd1);
	localparam logic signed [FIELD_W-1:0] VMIN32 = ~VMAX32;
	localparam logic [FIELD_W-1:0] CMAX32 = (CW >= FIELD_W) ? 32'hffff_ffff :
		FIELD_W'((64'd1 << CW) - 64'd1);
	localparam logic [BW-1:0] LAST_BIT = BW'(VW - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         acc_q;
	logic signed [VW-1:0]  mean_q;
	logic [CW-1:0]         cnt_q;
	logic signed [VW-1:0]  smean_q;
	logic [CW-1:0]         total_q;
	logic                  sat_q;
	logic                  up_q;
	logic [VW-1:0]         mag_q;
	logic [CW-1:0]         rem_q;
	logic [VW-1:0]         quo_q;
	logic [BW-1:0]         bit_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_sat_q;

	logic                  in_fire;
	logic                  out_free;
	logic signed [FIELD_W-1:0] in_mean;
	logic signed [FIELD_W-1:0] in_mean_c;
	logic [FIELD_W-1:0]    in_cnt;
	logic [FIELD_W-1:0]    in_cnt_c;
	logic [63:0]           in_mean64;
	logic [63:0]           in_cnt64;
	logic [CW:0]           sum;
	logic                  sum_sat;
	logic [CW-1:0]         total;
	logic signed [VW:0]    diff;
	logic signed [VW:0]    diff_neg;
	logic [CW+1:0]         r_sh;
	logic [CW+1:0]         t_one;
	logic [CW+1:0]         t_two;
	logic [CW+1:0]         r_next;
	logic [1:0]            digit;
	logic [63:0]           acc64;
	logic signed [63:0]    mean64;

	assign in_fire  = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = ~out_valid_q | m_tready;

	// Clamp the incoming fields to the state ranges.
	always_comb begin
		in_mean = signed'(s_tdata[2*FIELD_W-1:FIELD_W]);
		in_cnt  = s_tdata[FIELD_W-1:0];
		if (in_mean > VMAX32) begin
			in_mean_c = VMAX32;
		end else if (in_mean < VMIN32) begin
			in_mean_c = VMIN32;
		end else begin
			in_mean_c = in_mean;
		end
		in_cnt_c  = (in_cnt > CMAX32) ? CMAX32 : in_cnt;
		in_mean64 = 64'(in_mean_c);
		in_cnt64  = 64'(in_cnt_c);
	end

	// New total with saturation, and the signed distance between the means.
	always_comb begin
		sum      = {1'b0, acc_q} + {1'b0, cnt_q};
		sum_sat  = sum[CW];
		total    = sum_sat ? {CW{1'b1}} : sum[CW-1:0];
		diff     = {smean_q[VW-1], smean_q} - {mean_q[VW-1], mean_q};
		diff_neg = -diff;
	end

	// One divide step: bring in the next mean bit as count*bit, then take 0, 1 or 2 totals.
	always_comb begin
		r_sh  = {1'b0, rem_q, 1'b0} + (mag_q[VW-1] ? {2'b00, cnt_q} : '0);
		t_one = {2'b00, total_q};
		t_two = {1'b0, total_q, 1'b0};
		if (r_sh >= t_two) begin
			digit  = 2'd2;
			r_next = r_sh - t_two;
		end else if (r_sh >= t_one) begin
			digit  = 2'd1;
			r_next = r_sh - t_one;
		end else begin
			digit  = 2'd0;
			r_next = r_sh;
		end
	end

	// Sequencer and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			mean_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser[0]) begin
							acc_q  <= '0;
							mean_q <= '0;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (total == '0) begin
						mean_q  <= '0;
						state_q <= ST_WRITE;
					end else if (cnt_q == '0) begin
						state_q <= ST_WRITE;
					end else if (acc_q == '0) begin
						mean_q  <= smean_q;
						acc_q   <= total;
						state_q <= ST_WRITE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					mean_q  <= up_q ? mean_q + signed'(quo_q) : mean_q - signed'(quo_q);
					acc_q   <= total_q;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag: set by the final step, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_WRITE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Request capture and divide datapath.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cnt_q   <= in_cnt64[CW-1:0];
			smean_q <= signed'(in_mean64[VW-1:0]);
		end
		if (state_q == ST_SETUP) begin
			total_q <= total;
			sat_q   <= sum_sat;
			up_q    <= ~diff[VW];
			mag_q   <= diff[VW] ? diff_neg[VW-1:0] : diff[VW-1:0];
			rem_q   <= '0;
			quo_q   <= '0;
			bit_q   <= LAST_BIT;
		end
		if (state_q == ST_DIV) begin
			rem_q <= r_next[CW-1:0];
			quo_q <= (quo_q << 1) + VW'(digit);
			mag_q <= mag_q << 1;
			bit_q <= bit_q - 1'b1;
		end
		if ((state_q == ST_WRITE) && out_free) begin
			out_data_q <= {mean64[FIELD_W-1:0], acc64[FIELD_W-1:0]};
			out_sat_q  <= sat_q & (cnt_q != '0);
		end
	end

	assign acc64  = 64'(acc_q);
	assign mean64 = 64'(mean_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

endmodule

// ----- rtl/rmm_checker.sv -----
module running_mean_merge_sva
	import rmm_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,   // sample_count[31:0], sample_mean[63:32]
	input logic [IN_USER_W-1:0]  s_tuser,   // restart[0]
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,   // total_count[31:0], mean_value[63:32]
	input logic [OUT_USER_W-1:0] m_tuser    // count_saturated[0]
);

	localparam logic [FIELD_W-1:0] CMAX32 = (COUNT_WIDTH >= FIELD_W) ? 32'hffff_ffff :
		FIELD_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	// A taken request keeps the block busy for at least the next cycle.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block took two requests in a row");

	// Returning to idle always comes with a fresh result in the output register.
	a_result_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("block went idle without a result");

	// A saturated result reports the clamped count.
	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[FIELD_W-1:0] == CMAX32)
		else $error("saturated result with unclamped count");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind running_mean_merge running_mean_merge_sva #(.COUNT_WIDTH(COUNT_WIDTH)) u_rmm_sva (.*);
